[rtl/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg
// Shared codes, widths and the request plan passed from the front end to the
// command sequencer of the block residency and allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int ADDR_BITS_DEFAULT = 32;
    localparam int ADDR_BITS_MAX     = 64;
    localparam int FIELD_BITS        = 32;
    localparam int OP_BITS           = 3;
    localparam int CMD_BITS          = 3;
    localparam int CHUNK_BITS        = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CHUNK_BITS-1:0] CHUNK_RESET = 16'd100;
    localparam logic [FIELD_BITS-1:0] ROOT_BLOCK  = 32'd1;
    localparam logic [FIELD_BITS-1:0] FIRST_FREE  = 32'd2;
    localparam logic [FIELD_BITS-1:0] INFO_BLOCK  = 32'd0;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_SWITCH  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_DIRTY   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_MOUNT   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_UNMOUNT = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FORMAT  = 3'd4;

    // Storage command codes
    localparam logic [CMD_BITS-1:0] CMD_DONE  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_INFO  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_BLANK = 3'd4;

    localparam int IN_DATA_BITS  = 160;
    localparam int OUT_DATA_BITS = 136;

    // Everything the sequencer needs to issue one request's commands.
    typedef struct packed {
        logic [1:0]            n_cmds;
        logic [CMD_BITS-1:0]   cmd_a;
        logic [FIELD_BITS-1:0] addr_a;
        logic [CMD_BITS-1:0]   cmd_b;
        logic [FIELD_BITS-1:0] addr_b;
        logic [FIELD_BITS-1:0] info_start;
        logic [FIELD_BITS-1:0] info_free;
        logic [FIELD_BITS-1:0] info_end;
        logic [FIELD_BITS-1:0] done_addr;
        logic                  past_end;
    } plan_t;

endpackage

[rtl/bra_front.sv]
// ----------------------------------------------------------------------------
// bra_front
// Accepts requests, updates the residency and allocator state and turns each
// request into a plan of storage commands.
// ----------------------------------------------------------------------------
module bra_front #(
    parameter int BLOCK_ADDR_BITS = bra_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bra_pkg::CHUNK_BITS-1:0]   cfg_wdata,
    input  logic                             req_valid,
    input  logic [bra_pkg::OP_BITS-1:0]      operation,
    input  logic [bra_pkg::FIELD_BITS-1:0]   target_block,
    input  logic [bra_pkg::FIELD_BITS-1:0]   mounted_start,
    input  logic [bra_pkg::FIELD_BITS-1:0]   mounted_free,
    input  logic [bra_pkg::FIELD_BITS-1:0]   mounted_end,
    input  logic [bra_pkg::FIELD_BITS-1:0]   disk_blocks,
    input  logic                             queue_full,
    output logic                             push,
    output bra_pkg::plan_t                   plan
);
    import bra_pkg::*;

    localparam int AB = BLOCK_ADDR_BITS;
    localparam int CW = BLOCK_ADDR_BITS + CHUNK_BITS;

    logic [CHUNK_BITS-1:0] chunk_reg, chunk_next;
    logic [AB-1:0] root_reg, root_next;
    logic [AB-1:0] free_reg, free_next;
    logic [AB-1:0] end_reg, end_next;
    logic [AB-1:0] cursor_reg, cursor_next;
    logic [AB-1:0] res_reg, res_next;
    logic          dirty_reg, dirty_next;

    logic [AB-1:0] target;
    logic [AB-1:0] diff;
    logic [AB-1:0] grown_free;
    logic          need_wb;
    logic          reserve;
    logic          past;
    logic          has_second;
    logic [CMD_BITS-1:0]   second_cmd;
    logic [AB-1:0]         second_addr;

    function automatic logic [AB-1:0] to_addr(input logic [FIELD_BITS-1:0] v);
        logic [ADDR_BITS_MAX-1:0] w;
        begin
            w = ADDR_BITS_MAX'(v);
            return w[AB-1:0];
        end
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [AB-1:0] v);
        logic [ADDR_BITS_MAX-1:0] w;
        begin
            w = ADDR_BITS_MAX'(v);
            return w[FIELD_BITS-1:0];
        end
    endfunction

    assign push   = req_valid && !queue_full;
    assign target = to_addr(target_block);
    assign diff   = end_reg - free_reg;
    assign need_wb = dirty_reg && (res_reg != '0);
    assign reserve = (cursor_reg == free_reg) && (free_reg < end_reg);
    assign grown_free = AB'(CW'(free_reg) + CW'(chunk_reg));

    always_comb
    begin
        chunk_next  = cfg_we ? cfg_wdata : chunk_reg;
        root_next   = root_reg;
        free_next   = free_reg;
        end_next    = end_reg;
        cursor_next = cursor_reg;
        res_next    = res_reg;
        dirty_next  = dirty_reg;
        past        = 1'b0;
        has_second  = 1'b0;
        second_cmd  = CMD_DONE;
        second_addr = '0;
        plan.n_cmds = 2'd0;

        case (operation)
            OP_SWITCH:
            begin
                if (!(target != '0 && target == res_reg))
                begin
                    if (target != '0)
                    begin
                        has_second  = 1'b1;
                        second_cmd  = CMD_READ;
                        second_addr = target;
                        dirty_next  = 1'b0;
                        res_next    = target;
                    end
                    else
                    begin
                        if (reserve)
                        begin
                            has_second  = 1'b1;
                            second_cmd  = CMD_INFO;
                            second_addr = AB'(INFO_BLOCK);
                            free_next   = (CW'(diff) > CW'(chunk_reg)) ? grown_free : end_reg;
                        end
                        past        = cursor_reg >= end_reg;
                        cursor_next = cursor_reg + 1'b1;
                        dirty_next  = 1'b1;
                        res_next    = cursor_reg;
                    end
                    plan.n_cmds = 2'(has_second) + 2'(need_wb);
                end
            end
            OP_DIRTY:
            begin
                dirty_next = 1'b1;
            end
            OP_MOUNT:
            begin
                root_next   = to_addr(mounted_start);
                free_next   = to_addr(mounted_free);
                end_next    = to_addr(mounted_end);
                cursor_next = to_addr(mounted_free);
                has_second  = 1'b1;
                second_cmd  = CMD_READ;
                second_addr = AB'(INFO_BLOCK);
                plan.n_cmds = 2'd1;
            end
            OP_UNMOUNT:
            begin
                if (free_reg > cursor_reg)
                begin
                    free_next = cursor_reg;
                end
                has_second  = 1'b1;
                second_cmd  = CMD_INFO;
                second_addr = AB'(INFO_BLOCK);
                plan.n_cmds = 2'd1 + 2'(need_wb);
            end
            OP_FORMAT:
            begin
                root_next   = AB'(ROOT_BLOCK);
                free_next   = AB'(FIRST_FREE);
                cursor_next = AB'(FIRST_FREE);
                end_next    = to_addr(disk_blocks);
                plan.n_cmds = 2'd2;
            end
            default:
            begin
                plan.n_cmds = 2'd0;
            end
        endcase

        if (!push)
        begin
            root_next   = root_reg;
            free_next   = free_reg;
            end_next    = end_reg;
            cursor_next = cursor_reg;
            res_next    = res_reg;
            dirty_next  = dirty_reg;
        end

        // The write-back, when present, always goes ahead of the other command.
        if (operation == OP_FORMAT)
        begin
            plan.cmd_a  = CMD_BLANK;
            plan.addr_a = ROOT_BLOCK;
            plan.cmd_b  = CMD_INFO;
            plan.addr_b = INFO_BLOCK;
        end
        else if (need_wb && operation != OP_MOUNT)
        begin
            plan.cmd_a  = CMD_WRITE;
            plan.addr_a = to_field(res_reg);
            plan.cmd_b  = second_cmd;
            plan.addr_b = to_field(second_addr);
        end
        else
        begin
            plan.cmd_a  = second_cmd;
            plan.addr_a = to_field(second_addr);
            plan.cmd_b  = CMD_DONE;
            plan.addr_b = '0;
        end

        // Info contents and the done address are taken after this request's update.
        plan.info_start = to_field(root_next);
        plan.info_free  = to_field(free_next);
        plan.info_end   = to_field(end_next);
        plan.done_addr  = to_field(res_next);
        plan.past_end   = past;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= CHUNK_RESET;
            root_reg   <= '0;
            free_reg   <= '0;
            end_reg    <= '0;
            cursor_reg <= '0;
            res_reg    <= '0;
            dirty_reg  <= 1'b0;
        end
        else
        begin
            chunk_reg  <= chunk_next;
            root_reg   <= root_next;
            free_reg   <= free_next;
            end_reg    <= end_next;
            cursor_reg <= cursor_next;
            res_reg    <= res_next;
            dirty_reg  <= dirty_next;
        end
    end

    a_format_state: assert property (@(posedge clk) disable iff (!rst_n)
        push && operation == OP_FORMAT |=>
            free_reg == AB'(FIRST_FREE) && cursor_reg == AB'(FIRST_FREE))
        else $error("format did not set the free pointer and cursor");

    a_reserve_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        push && operation == OP_SWITCH && target == '0 && reserve |=>
            free_reg <= end_reg && free_reg > $past(free_reg))
        else $error("chunk reservation left the disk range");

endmodule

[rtl/bra_queue.sv]
// ----------------------------------------------------------------------------
// bra_queue
// Short plan queue between the front end and the command sequencer.
// ----------------------------------------------------------------------------
module bra_queue #(
    parameter int DEPTH = bra_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bra_pkg::plan_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output bra_pkg::plan_t  head
);
    import bra_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    plan_t            slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH) && !(push && full) && !(pop && empty))
        else $error("plan queue overflow or underflow");

endmodule

[rtl/bra_back.sv]
// ----------------------------------------------------------------------------
// bra_back
// Command sequencer: walks the plan at the queue head and issues one result
// per cycle, while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module bra_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                empty,
    input  bra_pkg::plan_t                      head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bra_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic [bra_pkg::CMD_BITS-1:0]        m_tuser,
    output logic                                m_tlast
);
    import bra_pkg::*;

    logic [1:0]               idx_reg, idx_next;
    logic                     valid_reg, valid_next;
    logic [OUT_DATA_BITS-1:0] data_reg, data_next;
    logic [CMD_BITS-1:0]      cmd_reg, cmd_next;
    logic                     last_reg, last_next;

    logic                     load;
    logic                     emit;
    logic                     is_done;
    logic                     is_info;
    logic [FIELD_BITS-1:0]    addr;

    assign load    = !valid_reg || m_tready;
    assign emit    = load && !empty;
    assign is_done = (idx_reg == head.n_cmds);
    assign pop     = emit && is_done;

    always_comb
    begin
        if (is_done)
        begin
            cmd_next = CMD_DONE;
            addr     = head.done_addr;
        end
        else if (idx_reg == 2'd0)
        begin
            cmd_next = head.cmd_a;
            addr     = head.addr_a;
        end
        else
        begin
            cmd_next = head.cmd_b;
            addr     = head.addr_b;
        end
        is_info = (cmd_next == CMD_INFO);

        // Info contents are zero on every result except the info write.
        data_next = {7'd0,
                     is_done && head.past_end,
                     is_info ? head.info_end   : 32'd0,
                     is_info ? head.info_free  : 32'd0,
                     is_info ? head.info_start : 32'd0,
                     addr};
        last_next = is_done;

        if (emit)
        begin
            idx_next   = is_done ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else
        begin
            idx_next   = idx_reg;
            valid_next = m_tready ? 1'b0 : valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= data_next;
            cmd_reg  <= cmd_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = cmd_reg;
    assign m_tlast  = last_reg;

    a_idx_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg <= head.n_cmds)
        else $error("sequencer index beyond the plan");

    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_reg == (cmd_reg == CMD_DONE)))
        else $error("last flag does not match the done command");

    a_idx_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("sequencer index not rewound after a request");

endmodule

[rtl/block_residency_and_allocator.sv]
// ----------------------------------------------------------------------------
// block_residency_and_allocator
// Single resident write-back block controller with a chunked block allocator.
// ----------------------------------------------------------------------------
// Each request produces its storage commands (write-back, read, info write,
// blank root) followed by one done result carrying tlast, so one request
// yields one to three results. The front end updates all state in the cycle a
// request is accepted and can take a new request every cycle while its
// two-entry plan queue has room; the command sequencer then issues one result
// per cycle while the output is not stalled, each request holding the output
// until all of its results are taken, and that sequencer sets the sustained rate.
module block_residency_and_allocator #(
    parameter int BLOCK_ADDR_BITS = bra_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bra_pkg::CHUNK_BITS-1:0]      cfg_wdata,    // checkout_chunk
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target_block, mounted_start, mounted_free, mounted_end, disk_blocks
    input  logic [bra_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic [bra_pkg::OP_BITS-1:0]         s_tuser,      // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // block_address, info_start_out, info_free_out, info_end_out, past_end
    output logic [bra_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic [bra_pkg::CMD_BITS-1:0]        m_tuser,      // command
    output logic                                m_tlast       // last
);
    import bra_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    plan_t plan;
    plan_t head;

    assign s_tready = !full;

    bra_front #(
        .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (s_tvalid),
        .operation     (s_tuser),
        .target_block  (s_tdata[31:0]),
        .mounted_start (s_tdata[63:32]),
        .mounted_free  (s_tdata[95:64]),
        .mounted_end   (s_tdata[127:96]),
        .disk_blocks   (s_tdata[159:128]),
        .queue_full    (full),
        .push          (push),
        .plan          (plan)
    );

    bra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (plan),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    bra_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_residency_and_allocator. Requests go in
// through the slave stream and storage commands come back on the master
// stream. A shadow copy of the residency and allocator state predicts each
// request's commands when the request is accepted. Every returned command is
// checked field by field against the oldest prediction. The chunk register is
// moved between phases, and each side of the stream stalls at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [OP_BITS-1:0] OP_UNDEF_LAST  = 3'd7;
    localparam int LONG_HOLD_CYCLES = 90;
    localparam int PHASE_REQS       = 24;

    typedef struct {
        logic [OP_BITS-1:0]    op;
        logic [FIELD_BITS-1:0] target;
        logic [FIELD_BITS-1:0] mnt_start;
        logic [FIELD_BITS-1:0] mnt_free;
        logic [FIELD_BITS-1:0] mnt_end;
        logic [FIELD_BITS-1:0] disk_blocks;
        bit                    use_resident;   // target taken from the resident block
    } req_t;

    typedef struct {
        logic [CMD_BITS-1:0]   cmd;
        logic [FIELD_BITS-1:0] addr;
        logic [FIELD_BITS-1:0] info_start;
        logic [FIELD_BITS-1:0] info_free;
        logic [FIELD_BITS-1:0] info_end;
        logic                  past_end;
        logic                  is_last;
    } cmd_result_t;

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     cfg_we     = 1'b0;
    logic [CHUNK_BITS-1:0]    cfg_wdata  = '0;
    logic                     s_tvalid   = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata    = '0;
    logic [OP_BITS-1:0]       s_tuser    = '0;
    logic                     m_tvalid;
    logic                     m_tready   = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [CMD_BITS-1:0]      m_tuser;
    logic                     m_tlast;

    // Shadow of the block state.
    logic [CHUNK_BITS-1:0] pred_chunk    = CHUNK_RESET;
    logic [FIELD_BITS-1:0] pred_root     = '0;
    logic [FIELD_BITS-1:0] pred_free     = '0;
    logic [FIELD_BITS-1:0] pred_end      = '0;
    logic [FIELD_BITS-1:0] pred_cursor   = '0;
    logic [FIELD_BITS-1:0] pred_resident = '0;
    logic                  pred_dirty    = 1'b0;

    req_t        pending_reqs[$];
    cmd_result_t expected_cmds[$];
    req_t        cur_req;
    cmd_result_t want;

    int unsigned send_idle_pct   = 24;
    int unsigned recv_idle_pct   = 47;
    int unsigned total_queued    = 0;
    int unsigned reqs_accepted   = 0;
    int unsigned results_seen    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned hold_left       = 0;
    bit          start_long_hold = 1'b0;
    bit          hold_used       = 1'b0;

    block_residency_and_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_result(logic [CMD_BITS-1:0] cmd, logic [FIELD_BITS-1:0] addr,
                                        bit with_info, logic past);
        cmd_result_t r;
        r.cmd        = cmd;
        r.addr       = addr;
        r.info_start = with_info ? pred_root : '0;
        r.info_free  = with_info ? pred_free : '0;
        r.info_end   = with_info ? pred_end  : '0;
        r.past_end   = past;
        r.is_last    = (cmd == CMD_DONE);
        expected_cmds.push_back(r);
    endfunction

    function automatic void predict_commands(req_t r);
        logic [FIELD_BITS-1:0] tgt;
        logic                  past;
        tgt  = r.target;
        past = 1'b0;
        case (r.op)
            OP_SWITCH:
            begin
                if (tgt != '0 && tgt == pred_resident)
                begin
                    push_result(CMD_DONE, pred_resident, 1'b0, 1'b0);
                    return;
                end
                if (pred_dirty && pred_resident != '0)
                    push_result(CMD_WRITE, pred_resident, 1'b0, 1'b0);
                if (tgt != '0)
                begin
                    push_result(CMD_READ, tgt, 1'b0, 1'b0);
                    pred_dirty = 1'b0;
                end
                else
                begin
                    // A new chunk is checked out only when the current one is used up.
                    if (pred_cursor == pred_free && pred_free < pred_end)
                    begin
                        if (pred_end - pred_free > {16'd0, pred_chunk})
                            pred_free = pred_free + {16'd0, pred_chunk};
                        else
                            pred_free = pred_end;
                        push_result(CMD_INFO, INFO_BLOCK, 1'b1, 1'b0);
                    end
                    tgt         = pred_cursor;
                    past        = (tgt >= pred_end);
                    pred_cursor = pred_cursor + 1'b1;
                    pred_dirty  = 1'b1;
                end
                pred_resident = tgt;
            end
            OP_DIRTY:
                pred_dirty = 1'b1;
            OP_MOUNT:
            begin
                pred_root   = r.mnt_start;
                pred_free   = r.mnt_free;
                pred_end    = r.mnt_end;
                pred_cursor = r.mnt_free;
                push_result(CMD_READ, INFO_BLOCK, 1'b0, 1'b0);
            end
            OP_UNMOUNT:
            begin
                // The write-back leaves the dirty flag set.
                if (pred_dirty && pred_resident != '0)
                    push_result(CMD_WRITE, pred_resident, 1'b0, 1'b0);
                if (pred_free > pred_cursor)
                    pred_free = pred_cursor;
                push_result(CMD_INFO, INFO_BLOCK, 1'b1, 1'b0);
            end
            OP_FORMAT:
            begin
                push_result(CMD_BLANK, ROOT_BLOCK, 1'b0, 1'b0);
                pred_root   = ROOT_BLOCK;
                pred_free   = FIRST_FREE;
                pred_cursor = FIRST_FREE;
                pred_end    = r.disk_blocks;
                push_result(CMD_INFO, INFO_BLOCK, 1'b1, 1'b0);
            end
            default:
                ;
        endcase
        push_result(CMD_DONE, pred_resident, 1'b0, past);
    endfunction

    function automatic void check_field(string what, logic [FIELD_BITS-1:0] want_v,
                                        logic [FIELD_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Request driver: holds a request until it is taken, idles only between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_commands(cur_req);
                reqs_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    if (cur_req.use_resident)
                        cur_req.target = pred_resident;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.op;
                    s_tdata  <= {cur_req.disk_blocks, cur_req.mnt_end, cur_req.mnt_free,
                                 cur_req.mnt_start, cur_req.target};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (start_long_hold && !hold_used)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual command %0d address %h",
                             $time, m_tuser, m_tdata[31:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("command", FIELD_BITS'(want.cmd), FIELD_BITS'(m_tuser));
                    check_field("block_address", want.addr, m_tdata[31:0]);
                    check_field("info_start", want.info_start, m_tdata[63:32]);
                    check_field("info_free", want.info_free, m_tdata[95:64]);
                    check_field("info_end", want.info_end, m_tdata[127:96]);
                    check_field("past_end", FIELD_BITS'(want.past_end),
                                FIELD_BITS'(m_tdata[128]));
                    check_field("last", FIELD_BITS'(want.is_last), FIELD_BITS'(m_tlast));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void queue_req(logic [OP_BITS-1:0] op, logic [FIELD_BITS-1:0] target,
                                      logic [FIELD_BITS-1:0] mnt_start,
                                      logic [FIELD_BITS-1:0] mnt_free,
                                      logic [FIELD_BITS-1:0] mnt_end,
                                      logic [FIELD_BITS-1:0] disk_blocks, bit use_resident);
        req_t r;
        r.op           = op;
        r.target       = target;
        r.mnt_start    = mnt_start;
        r.mnt_free     = mnt_free;
        r.mnt_end      = mnt_end;
        r.disk_blocks  = disk_blocks;
        r.use_resident = use_resident;
        pending_reqs.push_back(r);
        total_queued++;
    endfunction

    // Session: format, mount or any op, then switch, dirty, unmount and undefined ops.
    task automatic queue_random_session(int unsigned span);
        int unsigned           roll;
        int unsigned           body_len;
        logic [FIELD_BITS-1:0] base;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            queue_req(OP_FORMAT, $urandom, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span), 1'b0);
        else if (roll < 85)
        begin
            base = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2000);
            queue_req(OP_MOUNT, $urandom, $urandom, base,
                      ($urandom_range(0, 5) == 0) ? $urandom_range(0, base)
                                                  : base + $urandom_range(0, span),
                      $urandom, 1'b0);
        end
        else
            queue_req(OP_BITS'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                      $urandom, 1'b0);
        body_len = $urandom_range(3, 10);
        repeat (body_len)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                queue_req(OP_SWITCH, '0, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else if (roll < 55)
                queue_req(OP_SWITCH, $urandom_range(1, 24), $urandom, $urandom, $urandom,
                          $urandom, 1'b0);
            else if (roll < 63)
                queue_req(OP_SWITCH, '0, $urandom, $urandom, $urandom, $urandom, 1'b1);
            else if (roll < 68)
                queue_req(OP_SWITCH, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else if (roll < 82)
                queue_req(OP_DIRTY, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else if (roll < 94)
                queue_req(OP_UNMOUNT, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else
                queue_req(OP_BITS'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), $urandom,
                          $urandom, $urandom, $urandom, $urandom, 1'b0);
        end
    endtask

    // Checked at the falling edge so that the posedge processes have settled.
    task automatic wait_until_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(logic [CHUNK_BITS-1:0] chunk, int unsigned send_pct,
                                    int unsigned recv_pct, bit long_hold);
        int unsigned goal;
        wait_until_idle();
        repeat (4) @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= chunk;
        pred_chunk = chunk;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = total_queued + PHASE_REQS;
        while (total_queued < goal)
            queue_random_session(3 * chunk + 20);
        if (long_hold)
            start_long_hold = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the chunk still at its reset value.
        queue_req(OP_SWITCH, '0, '1, '1, '1, '1, 1'b0);     // allocation on an unmounted disk
        queue_req(OP_DIRTY, '1, '0, '0, '0, '0, 1'b0);      // dirty with nothing resident
        queue_req(OP_SWITCH, 32'd5, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SWITCH, 32'd5, '0, '0, '0, '0, 1'b0);  // already resident
        queue_req(OP_DIRTY, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SWITCH, '1, '0, '0, '0, '0, 1'b0);
        queue_req(OP_UNMOUNT, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_FORMAT, '0, '0, '0, '0, 32'd10, 1'b0);
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_UNMOUNT, '0, '0, '0, '0, '0, 1'b0);    // gives back unused blocks
        queue_req(OP_MOUNT, '0, 32'd1, 32'd4, 32'd5, '0, 1'b0);
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);     // reservation clamped at the end
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);     // disk full
        queue_req(OP_MOUNT, '0, '1, '1, '1, '0, 1'b0);
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);     // cursor wraps around
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_DIRTY, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SWITCH, 32'd7, '0, '0, '0, '0, 1'b0);
        queue_req(OP_FORMAT, '0, '0, '0, '0, '0, 1'b0);
        queue_req(OP_SWITCH, '0, '0, '0, '0, '0, 1'b0);
        for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++)
            queue_req(OP_BITS'(op), $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        queue_req(OP_MOUNT, '0, '0, '0, '0, '0, 1'b0);

        run_random_phase(16'd1, 24, 47, 1'b0);
        run_random_phase(16'hFFFF, 47, 24, 1'b0);
        run_random_phase(CHUNK_BITS'($urandom_range(2, 7)), 0, 0, 1'b1);

        wait_until_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d requests and %0d storage commands", reqs_accepted, results_seen);
        $display("over chunk sizes 100, 1, 65535 and a small one, with stalls on both sides.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_400_000;
        $display("Timed out with %0d requests and %0d results still outstanding",
                 pending_reqs.size(), expected_cmds.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
